// ===== hw/rtl/iaid_pkg.sv =====
// Package for the indexed array block: payload types, codes and the control-store program.
package iaid_pkg;

  localparam int ValueW  = 32;
  localparam int FuncW   = 3;
  localparam int PosW    = 7;
  localparam int StatusW = 2;
  localparam int CountW  = 8;
  localparam int StepW   = 4;

  // Request function codes.
  localparam logic [FuncW-1:0] FUNC_CLEAR  = 3'd0;
  localparam logic [FuncW-1:0] FUNC_APPEND = 3'd1;
  localparam logic [FuncW-1:0] FUNC_INSERT = 3'd2;
  localparam logic [FuncW-1:0] FUNC_UPDATE = 3'd3;
  localparam logic [FuncW-1:0] FUNC_DELETE = 3'd4;
  localparam logic [FuncW-1:0] FUNC_READ   = 3'd5;

  // Result status codes.
  localparam logic [StatusW-1:0] STAT_OK     = 2'd0;
  localparam logic [StatusW-1:0] STAT_BADPOS = 2'd1;
  localparam logic [StatusW-1:0] STAT_FULL   = 2'd2;
  localparam logic [StatusW-1:0] STAT_EMPTY  = 2'd3;

  typedef struct packed {
    logic [FuncW-1:0]         func;
    logic [PosW-1:0]          position;
    logic signed [ValueW-1:0] value;
  } req_t;

  typedef struct packed {
    logic [StatusW-1:0]       status;
    logic signed [ValueW-1:0] read_value;
    logic [CountW-1:0]        count;
  } rsp_t;

  // Control-store addresses.
  typedef logic [StepW-1:0] step_t;
  localparam step_t ST_IDLE   = 4'd0;
  localparam step_t ST_CLR    = 4'd1;
  localparam step_t ST_APP    = 4'd2;
  localparam step_t ST_UPD    = 4'd3;
  localparam step_t ST_RD     = 4'd4;
  localparam step_t ST_RDCAP  = 4'd5;
  localparam step_t ST_SHCHK  = 4'd6;
  localparam step_t ST_SHRD   = 4'd7;
  localparam step_t ST_SHLP   = 4'd8;
  localparam step_t ST_SHLAST = 4'd9;
  localparam step_t ST_SHEND  = 4'd10;
  localparam step_t ST_INSPUT = 4'd11;
  localparam step_t ST_DELFIN = 4'd12;
  localparam step_t ST_RESP   = 4'd13;

  // Sequencer branch conditions.
  typedef enum logic [2:0] {
    COND_NEXT      = 3'd0,
    COND_ALWAYS    = 3'd1,
    COND_DISPATCH  = 3'd2,
    COND_LEFT_ZERO = 3'd3,
    COND_LAST_ONE  = 3'd4,
    COND_NOT_LAST  = 3'd5,
    COND_IS_DEL    = 3'd6,
    COND_WAIT_OUT  = 3'd7
  } cond_t;

  typedef enum logic [1:0] {
    WR_NONE    = 2'd0,
    WR_SHIFT   = 2'd1,
    WR_VAL_POS = 2'd2,
    WR_VAL_CNT = 2'd3
  } wr_sel_t;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_ZERO = 2'd1,
    CNT_INC  = 2'd2,
    CNT_DEC  = 2'd3
  } cnt_op_t;

  typedef enum logic {
    RD_PTR = 1'b0,
    RD_POS = 1'b1
  } rd_sel_t;

  typedef struct packed {
    logic    rd_en;
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    logic    sh_adv;
    cnt_op_t cnt_op;
    logic    cap_rd;
    logic    emit;
    cond_t   cond;
    step_t   target;
  } uop_t;

  function automatic uop_t uop_rom(input step_t step);
    uop_t u;
    u = '{rd_en: 1'b0, rd_sel: RD_PTR, wr_sel: WR_NONE, sh_adv: 1'b0, cnt_op: CNT_HOLD,
          cap_rd: 1'b0, emit: 1'b0, cond: COND_NEXT, target: ST_IDLE};
    unique case (step)
      ST_IDLE: begin
        u.cond = COND_DISPATCH;
      end
      ST_CLR: begin
        u.cnt_op = CNT_ZERO;
        u.cond   = COND_ALWAYS;
        u.target = ST_RESP;
      end
      ST_APP: begin
        u.wr_sel = WR_VAL_CNT;
        u.cnt_op = CNT_INC;
        u.cond   = COND_ALWAYS;
        u.target = ST_RESP;
      end
      ST_UPD: begin
        u.wr_sel = WR_VAL_POS;
        u.cond   = COND_ALWAYS;
        u.target = ST_RESP;
      end
      ST_RD: begin
        u.rd_en  = 1'b1;
        u.rd_sel = RD_POS;
      end
      ST_RDCAP: begin
        u.cap_rd = 1'b1;
        u.cond   = COND_ALWAYS;
        u.target = ST_RESP;
      end
      ST_SHCHK: begin
        u.cond   = COND_LEFT_ZERO;
        u.target = ST_SHEND;
      end
      ST_SHRD: begin
        u.rd_en  = 1'b1;
        u.sh_adv = 1'b1;
        u.cond   = COND_LAST_ONE;
        u.target = ST_SHLAST;
      end
      ST_SHLP: begin
        u.rd_en  = 1'b1;
        u.wr_sel = WR_SHIFT;
        u.sh_adv = 1'b1;
        u.cond   = COND_NOT_LAST;
        u.target = ST_SHLP;
      end
      ST_SHLAST: begin
        u.wr_sel = WR_SHIFT;
      end
      ST_SHEND: begin
        u.cond   = COND_IS_DEL;
        u.target = ST_DELFIN;
      end
      ST_INSPUT: begin
        u.wr_sel = WR_VAL_POS;
        u.cnt_op = CNT_INC;
        u.cond   = COND_ALWAYS;
        u.target = ST_RESP;
      end
      ST_DELFIN: begin
        u.cnt_op = CNT_DEC;
      end
      ST_RESP: begin
        u.emit   = 1'b1;
        u.cond   = COND_WAIT_OUT;
        u.target = ST_IDLE;
      end
      default: begin
        u.cond   = COND_ALWAYS;
        u.target = ST_IDLE;
      end
    endcase
    return u;
  endfunction

endpackage

// ===== hw/rtl/iaid_if.sv =====
// Valid/ready channel interfaces for the request and result streams.
interface iaid_req_if;
  logic          valid;
  logic          ready;
  iaid_pkg::req_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface iaid_rsp_if;
  logic          valid;
  logic          ready;
  iaid_pkg::rsp_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== hw/rtl/iaid_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module iaid_ram #(
  parameter int Width = 32,
  parameter int Depth = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/indexed_array_insert_delete.sv =====
// Top level of the indexed array block: control-store sequencer, list datapath and result register.
//
// The block holds a packed list of up to DEPTH signed 32-bit words and a count.
// Requests arrive on in_ch (func, position, value); each one yields exactly one
// result on out_ch (status, read_value, count). A transaction takes place on a
// rising edge where valid and ready are both high.
// Requests are worked one at a time. Clear, append and update act in their
// own step, a read reads the RAM and then captures the word, and a rejected
// request or a spare code goes straight to the response step. An insert or
// delete checks the move count and walks the shift if entries move; then an
// insert writes the value and raises the count and a delete drops the count.
// The next request is taken the cycle after the result is in the output
// register. The shift rate is set by the element RAM: one read port and one
// write port, so a shift moves one entry per cycle, up to DEPTH - 1 entries.
// The output register lets the next request be accepted while a result waits;
// if the receiver stalls, the sequencer holds in its response step until the
// result slot frees, and the held result stays stable on out_ch.
// Reset clears the count and drops any pending result. The element RAM is not
// cleared; words are only read below the count, so they are always written.
module indexed_array_insert_delete #(
  parameter int DEPTH = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  iaid_req_if.sink          in_ch,
  iaid_rsp_if.source        out_ch
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > iaid_pkg::PosW) ? CW : iaid_pkg::PosW;
  localparam int XW   = (CW > iaid_pkg::CountW) ? CW : iaid_pkg::CountW;

  // Sequencer and control word.
  iaid_pkg::step_t step_r, step_nxt, disp_step;
  iaid_pkg::uop_t  uop;

  // Datapath registers.
  logic [CW-1:0]                     cnt_r, cnt_nxt;
  logic [CW-1:0]                     left_r, left_nxt;
  logic [AW-1:0]                     rp_r, rp_nxt;
  logic [AW-1:0]                     wa_r, wa_nxt;
  logic [AW-1:0]                     pos_r, pos_nxt;
  logic [iaid_pkg::ValueW-1:0]       val_r, val_nxt;
  logic [iaid_pkg::ValueW-1:0]       rd_r, rd_nxt;
  logic [iaid_pkg::StatusW-1:0]      st_r, st_nxt, disp_st;
  logic                              is_del_r, is_del_nxt;
  logic                              out_valid_r, out_valid_nxt;
  iaid_pkg::rsp_t                    out_data_r, out_data_nxt;

  // RAM port signals.
  logic                        ram_we, ram_re;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  logic [iaid_pkg::ValueW-1:0] ram_wdata, ram_rdata;

  logic            accept, out_free, emit_fire;
  logic [CMPW-1:0] cnt_c, pos_c, ins_left, del_left, ins_rp, del_rp;
  logic            list_full, list_empty;
  logic [XW-1:0]   cnt_x;

  assign uop       = iaid_pkg::uop_rom(step_r);
  assign in_ch.ready = (uop.cond == iaid_pkg::COND_DISPATCH);
  assign accept    = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign emit_fire = uop.emit && out_free;

  // Request decode: status checks and entry point into the program.
  assign cnt_c      = CMPW'(cnt_r);
  assign pos_c      = CMPW'(in_ch.data.position);
  assign list_full  = (cnt_r >= CW'(DEPTH));
  assign list_empty = (cnt_r == '0);
  assign ins_left   = cnt_c - pos_c;
  assign del_left   = cnt_c - pos_c - CMPW'(1);
  assign ins_rp     = cnt_c - CMPW'(1);
  assign del_rp     = pos_c + CMPW'(1);

  always_comb begin
    disp_st   = iaid_pkg::STAT_OK;
    disp_step = iaid_pkg::ST_RESP;
    unique case (in_ch.data.func)
      iaid_pkg::FUNC_CLEAR: begin
        disp_step = iaid_pkg::ST_CLR;
      end
      iaid_pkg::FUNC_APPEND: begin
        if (list_full) begin
          disp_st = iaid_pkg::STAT_FULL;
        end else begin
          disp_step = iaid_pkg::ST_APP;
        end
      end
      iaid_pkg::FUNC_INSERT: begin
        priority if (list_full) begin
          disp_st = iaid_pkg::STAT_FULL;
        end else if (pos_c > cnt_c) begin
          disp_st = iaid_pkg::STAT_BADPOS;
        end else begin
          disp_step = iaid_pkg::ST_SHCHK;
        end
      end
      iaid_pkg::FUNC_UPDATE, iaid_pkg::FUNC_DELETE, iaid_pkg::FUNC_READ: begin
        priority if (list_empty) begin
          disp_st = iaid_pkg::STAT_EMPTY;
        end else if (pos_c >= cnt_c) begin
          disp_st = iaid_pkg::STAT_BADPOS;
        end else if (in_ch.data.func == iaid_pkg::FUNC_UPDATE) begin
          disp_step = iaid_pkg::ST_UPD;
        end else if (in_ch.data.func == iaid_pkg::FUNC_DELETE) begin
          disp_step = iaid_pkg::ST_SHCHK;
        end else begin
          disp_step = iaid_pkg::ST_RD;
        end
      end
      default: begin
        disp_step = iaid_pkg::ST_RESP;
      end
    endcase
  end

  // Step counter with conditional jumps.
  always_comb begin
    unique case (uop.cond)
      iaid_pkg::COND_NEXT:      step_nxt = step_r + iaid_pkg::step_t'(1);
      iaid_pkg::COND_ALWAYS:    step_nxt = uop.target;
      iaid_pkg::COND_DISPATCH:  step_nxt = accept ? disp_step : step_r;
      iaid_pkg::COND_LEFT_ZERO: step_nxt = (left_r == '0) ? uop.target
                                                           : step_r + iaid_pkg::step_t'(1);
      iaid_pkg::COND_LAST_ONE:  step_nxt = (left_r == CW'(1)) ? uop.target
                                                               : step_r + iaid_pkg::step_t'(1);
      iaid_pkg::COND_NOT_LAST:  step_nxt = (left_r != CW'(1)) ? uop.target
                                                               : step_r + iaid_pkg::step_t'(1);
      iaid_pkg::COND_IS_DEL:    step_nxt = is_del_r ? uop.target
                                                    : step_r + iaid_pkg::step_t'(1);
      iaid_pkg::COND_WAIT_OUT:  step_nxt = out_free ? uop.target : step_r;
      default:                  step_nxt = iaid_pkg::ST_IDLE;
    endcase
  end

  // Datapath driven by the control word.
  always_comb begin
    pos_nxt    = pos_r;
    val_nxt    = val_r;
    is_del_nxt = is_del_r;
    st_nxt     = st_r;
    rd_nxt     = rd_r;
    left_nxt   = left_r;
    rp_nxt     = rp_r;
    wa_nxt     = wa_r;
    cnt_nxt    = cnt_r;

    if (accept) begin
      pos_nxt    = pos_c[AW-1:0];
      val_nxt    = in_ch.data.value;
      is_del_nxt = (in_ch.data.func == iaid_pkg::FUNC_DELETE);
      st_nxt     = disp_st;
      rd_nxt     = '0;
      if (in_ch.data.func == iaid_pkg::FUNC_DELETE) begin
        left_nxt = del_left[CW-1:0];
        rp_nxt   = del_rp[AW-1:0];
      end else begin
        left_nxt = ins_left[CW-1:0];
        rp_nxt   = ins_rp[AW-1:0];
      end
    end

    // Shift walk: inserts read downward and write one above, deletes read
    // upward and write one below.
    if (uop.sh_adv) begin
      left_nxt = left_r - CW'(1);
      if (is_del_r) begin
        rp_nxt = rp_r + AW'(1);
        wa_nxt = rp_r - AW'(1);
      end else begin
        rp_nxt = rp_r - AW'(1);
        wa_nxt = rp_r + AW'(1);
      end
    end

    if (uop.cap_rd) begin
      rd_nxt = ram_rdata;
    end

    unique case (uop.cnt_op)
      iaid_pkg::CNT_HOLD: cnt_nxt = cnt_r;
      iaid_pkg::CNT_ZERO: cnt_nxt = '0;
      iaid_pkg::CNT_INC:  cnt_nxt = cnt_r + CW'(1);
      iaid_pkg::CNT_DEC:  cnt_nxt = cnt_r - CW'(1);
      default:            cnt_nxt = cnt_r;
    endcase
  end

  // RAM port selection.
  always_comb begin
    ram_re    = uop.rd_en;
    ram_raddr = (uop.rd_sel == iaid_pkg::RD_POS) ? pos_r : rp_r;
    ram_we    = 1'b0;
    ram_waddr = wa_r;
    ram_wdata = ram_rdata;
    unique case (uop.wr_sel)
      iaid_pkg::WR_NONE: begin
        ram_we = 1'b0;
      end
      iaid_pkg::WR_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = wa_r;
        ram_wdata = ram_rdata;
      end
      iaid_pkg::WR_VAL_POS: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        ram_wdata = val_r;
      end
      iaid_pkg::WR_VAL_CNT: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r[AW-1:0];
        ram_wdata = val_r;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Result register. The count leaving the block keeps its low eight bits.
  assign cnt_x = XW'(cnt_r);

  always_comb begin
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit_fire) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.status     = st_r;
      out_data_nxt.read_value = rd_r;
      out_data_nxt.count      = cnt_x[iaid_pkg::CountW-1:0];
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= iaid_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    val_r      <= val_nxt;
    is_del_r   <= is_del_nxt;
    st_r       <= st_nxt;
    rd_r       <= rd_nxt;
    left_r     <= left_nxt;
    rp_r       <= rp_nxt;
    wa_r       <= wa_nxt;
    out_data_r <= out_data_nxt;
  end

  iaid_ram #(
    .Width(iaid_pkg::ValueW),
    .Depth(DEPTH)
  ) u_elem_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // A shift never writes the entry it is reading in the same cycle.
  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("RAM read and write hit the same entry");

  // The loop step consumes one move per cycle.
  a_left_decrements: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == iaid_pkg::ST_SHLP) |=> (left_r == $past(left_r) - CW'(1)))
    else $error("shift move counter did not step");

  // Decoding a request never touches the count.
  a_idle_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == iaid_pkg::ST_IDLE) |=> $stable(cnt_r))
    else $error("count changed during dispatch");

  // A new result only appears out of the response step.
  a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(step_r) == iaid_pkg::ST_RESP))
    else $error("result raised outside the response step");

  // The count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (uop.cnt_op == iaid_pkg::CNT_INC) |=> (cnt_r <= CW'(DEPTH)))
    else $error("count exceeded capacity");

endmodule

// ===== test/tb_indexed_array_insert_delete.sv =====
// Self-checking testbench for the indexed array block, with a list scoreboard and stream drivers.
`timescale 1ns / 100ps

module tb_indexed_array_insert_delete;
  import iaid_pkg::*;

  localparam int DEPTH = 128;

  // Function codes that the block treats as no operation.
  localparam logic [FuncW-1:0] FUNC_SPARE_A = 3'd6;
  localparam logic [FuncW-1:0] FUNC_SPARE_B = 3'd7;

  // Number of random transactions, and where the quiet end of the run begins.
  localparam int RANDOM_ITEMS = 850;
  localparam int QUIET_FROM   = 700;
  // Points in the random part where the receiver holds off for a long stretch
  // and where the sender waits for every expected result.
  localparam int HOLD_AT      = 150;
  localparam int PAUSE_AT     = 320;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN        = 2 * DEPTH + 20;
  localparam int LIMIT        = 600_000;

  // The list as the block should hold it, plus the results still owed.
  class list_scoreboard;
    logic signed [ValueW-1:0] words [DEPTH];
    logic [CountW-1:0]        live_count;
    rsp_t                     owed_q [$];
    int                       errors;

    function new();
      live_count = '0;
      errors     = 0;
    endfunction

    function int waiting();
      return owed_q.size();
    endfunction

    // Status of an update, delete or read at pos.
    function logic [StatusW-1:0] index_status(logic [PosW-1:0] pos);
      if (live_count == 0) return STAT_EMPTY;
      if ({1'b0, pos} >= live_count) return STAT_BADPOS;
      return STAT_OK;
    endfunction

    // Apply one accepted request to the list and queue the result it owes.
    function void note_request(req_t r);
      rsp_t e;
      int   i;
      e.status     = STAT_OK;
      e.read_value = '0;
      case (r.func)
        FUNC_CLEAR: begin
          live_count = '0;
        end
        FUNC_APPEND: begin
          if (live_count >= DEPTH) begin
            e.status = STAT_FULL;
          end else begin
            words[live_count[PosW-1:0]] = r.value;
            live_count++;
          end
        end
        FUNC_INSERT: begin
          // Fullness is checked before the position.
          if (live_count >= DEPTH) begin
            e.status = STAT_FULL;
          end else if ({1'b0, r.position} > live_count) begin
            e.status = STAT_BADPOS;
          end else begin
            for (i = live_count; i > r.position; i--) words[i] = words[i-1];
            words[r.position] = r.value;
            live_count++;
          end
        end
        FUNC_UPDATE: begin
          e.status = index_status(r.position);
          if (e.status == STAT_OK) words[r.position] = r.value;
        end
        FUNC_DELETE: begin
          e.status = index_status(r.position);
          if (e.status == STAT_OK) begin
            for (i = r.position; i + 1 < live_count; i++) words[i] = words[i+1];
            live_count--;
          end
        end
        FUNC_READ: begin
          e.status = index_status(r.position);
          if (e.status == STAT_OK) e.read_value = words[r.position];
        end
        default: begin
        end
      endcase
      e.count = live_count;
      owed_q.push_back(e);
    endfunction

    function void check_result(rsp_t got);
      rsp_t e;
      if (owed_q.size() == 0) begin
        $error("result with nothing expected: status %0d read_value %h count %0d",
               got.status, got.read_value, got.count);
        errors++;
        return;
      end
      e = owed_q.pop_front();
      if (got.status !== e.status) begin
        $error("status mismatch: expected %0d, actual %0d", e.status, got.status);
        errors++;
      end
      if (got.read_value !== e.read_value) begin
        $error("read_value mismatch: expected %h, actual %h", e.read_value, got.read_value);
        errors++;
      end
      if (got.count !== e.count) begin
        $error("count mismatch: expected %0d, actual %0d", e.count, got.count);
        errors++;
      end
    endfunction
  endclass

  // Random requests drift between filling the list, draining it and a mix,
  // so that full and empty lists and long shifts are all reached.
  typedef enum logic [1:0] {
    DRIFT_MIX,
    DRIFT_GROW,
    DRIFT_SHRINK
  } drift_t;

  logic clk = 1'b0;
  logic rst_n;

  iaid_req_if in_ch ();
  iaid_rsp_if out_ch ();

  indexed_array_insert_delete #(
    .DEPTH(DEPTH)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  list_scoreboard sb = new();

  drift_t drift    = DRIFT_MIX;
  bit     idle_on  = 1'b1;  // random idling on both sides
  bit     hold_out = 1'b0;  // asks the receiver for one long hold-off
  int     cycles   = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a correct run finishes far below the limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Every result transaction is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
  end

  // Result receiver. It stalls in random bursts, and once holds off for a long
  // stretch so that the block fills its result slot and stops taking requests.
  initial begin : result_sink
    int k;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_out) begin
        hold_out = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        k = $urandom_range(1, 15);
        out_ch.ready <= 1'b0;
        repeat (k) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offer one request and hold it until the block takes it. The caller sits
  // just after a rising edge, so valid stays high between back-to-back items.
  task automatic offer(input req_t r);
    in_ch.valid <= 1'b1;
    in_ch.data  <= r;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_request(r);
  endtask

  // Sometimes drop valid for a random burst after a transaction.
  task automatic sender_gap();
    int k;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      k = $urandom_range(1, 15);
      in_ch.valid <= 1'b0;
      repeat (k) @(posedge clk);
    end
  endtask

  task automatic send(input logic [FuncW-1:0] f, input int pos, input logic [31:0] v);
    req_t r;
    r.func     = f;
    r.position = pos[PosW-1:0];
    r.value    = v;
    offer(r);
    sender_gap();
  endtask

  function automatic logic [ValueW-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Build a random request around the current list length: mostly positions
  // inside the list, with the ends, one past the end and any position mixed in.
  function automatic req_t make_request();
    req_t        r;
    int unsigned w;
    int          n;
    int          hi;
    n = int'(sb.live_count);
    w = $urandom_range(0, 99);
    case (drift)
      DRIFT_GROW: begin
        r.func = (w < 40) ? FUNC_APPEND : (w < 85) ? FUNC_INSERT :
                 (w < 92) ? FUNC_READ   : (w < 96) ? FUNC_UPDATE :
                 (w < 98) ? FUNC_DELETE : (w[0] ? FUNC_SPARE_A : FUNC_SPARE_B);
      end
      DRIFT_SHRINK: begin
        r.func = (w < 55) ? FUNC_DELETE : (w < 75) ? FUNC_READ   :
                 (w < 85) ? FUNC_UPDATE : (w < 91) ? FUNC_INSERT :
                 (w < 97) ? FUNC_APPEND : (w < 98) ? FUNC_CLEAR  :
                 (w[0] ? FUNC_SPARE_A : FUNC_SPARE_B);
      end
      default: begin
        r.func = (w < 18) ? FUNC_APPEND : (w < 38) ? FUNC_INSERT :
                 (w < 55) ? FUNC_UPDATE : (w < 72) ? FUNC_DELETE :
                 (w < 94) ? FUNC_READ   : (w < 97) ? FUNC_CLEAR  :
                 (w[0] ? FUNC_SPARE_A : FUNC_SPARE_B);
      end
    endcase
    hi = (r.func == FUNC_INSERT) ? ((n >= DEPTH) ? DEPTH - 1 : n) : n - 1;
    if (hi < 0) hi = 0;
    if (hi > 127) hi = 127;
    case ($urandom_range(0, 9))
      0:       r.position = PosW'($urandom_range(0, 127));
      1:       r.position = '0;
      2:       r.position = hi[PosW-1:0];
      3:       r.position = PosW'((hi < 127) ? hi + 1 : hi);
      default: r.position = PosW'($urandom_range(0, hi));
    endcase
    r.value = pick_value();
    return r;
  endfunction

  // Growing ends only once the list is full, shrinking only once it is empty.
  task automatic update_drift();
    case (drift)
      DRIFT_GROW: begin
        if (sb.live_count >= DEPTH && $urandom_range(0, 4) == 0) drift = DRIFT_SHRINK;
      end
      DRIFT_SHRINK: begin
        if (sb.live_count == 0 && $urandom_range(0, 2) == 0) begin
          drift = $urandom_range(0, 1) ? DRIFT_GROW : DRIFT_MIX;
        end
      end
      default: begin
        if ($urandom_range(0, 49) == 0) begin
          drift = $urandom_range(0, 1) ? DRIFT_GROW : DRIFT_SHRINK;
        end
      end
    endcase
  endtask

  initial begin : stimulus
    int i;
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. An empty list rejects update, delete and read, and an
    // insert past the end is a bad position.
    send(FUNC_READ,   0,   32'h0);
    send(FUNC_UPDATE, 0,   32'h1234_5678);
    send(FUNC_DELETE, 127, 32'h0);
    send(FUNC_INSERT, 1,   32'h1);
    // Insert at the front, append, insert in the middle and at the end.
    send(FUNC_INSERT, 0,   32'h7fff_ffff);
    send(FUNC_APPEND, 0,   32'h8000_0000);
    send(FUNC_INSERT, 1,   32'hffff_ffff);
    send(FUNC_INSERT, 3,   32'h0);
    for (i = 0; i < 4; i++) send(FUNC_READ, i, 32'h0);
    // Positions at and beyond the end are flagged.
    send(FUNC_READ,   4,   32'h0);
    send(FUNC_UPDATE, 127, 32'h5555_5555);
    send(FUNC_DELETE, 4,   32'h0);
    send(FUNC_UPDATE, 2,   32'h5a5a_5a5a);
    send(FUNC_READ,   2,   32'h0);
    // Delete the first and then the last entry.
    send(FUNC_DELETE, 0,   32'h0);
    send(FUNC_DELETE, 2,   32'h0);
    send(FUNC_READ,   0,   32'h0);
    // The two spare codes do nothing.
    send(FUNC_SPARE_A, 127, 32'hdead_beef);
    send(FUNC_SPARE_B, 85,  32'h2aaa_aaaa);
    send(FUNC_CLEAR,   0,   32'hffff_ffff);
    send(FUNC_READ,    0,   32'h0);
    send(FUNC_APPEND,  42,  32'h0000_0001);

    // Random part. Fill and drain episodes reach a full list, where append and
    // insert are turned away, and long shifts in both directions.
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == QUIET_FROM) idle_on = 1'b0;
      if (i == HOLD_AT) hold_out = 1'b1;
      offer(make_request());
      update_drift();
      if (i == PAUSE_AT) begin
        // The sender stops until the block has returned everything it owes.
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.waiting() != 0) @(posedge clk);
      end else begin
        sender_gap();
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.waiting() != 0) @(posedge clk);
    // Give any stray result the time of a full shift to show up.
    repeat (DRAIN) @(posedge clk);

    if (sb.errors == 0 && sb.waiting() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
